>>> hw/rtl/pcm_pkg.sv
// Shared types and constants of the pixel colormap mapper.
package pcm_pkg;

   localparam int PALETTE_INDEX_BITS_DEF = 16;
   localparam int COLOR_BITS_DEF         = 32;

   localparam int PIXEL_BITS  = 16;
   localparam int SCALE_BITS  = 32;
   localparam int OFFSET_BITS = 49;
   localparam int X_BITS      = 16;
   localparam int EXP_BITS    = 5;
   localparam int FRAC_BITS   = 10;
   localparam int LOG_IN_BITS = PIXEL_BITS + 1;
   localparam int PROD_BITS   = SCALE_BITS + X_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int FRAC_SHIFT  = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = OFFSET_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_LOG_MODE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DATA_MIN  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DATA_MAX  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCALE     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_OFFSET    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOG_SHIFT = 3'd5;

   localparam logic [PIXEL_BITS-1:0]  DATA_MIN_RST = 16'h0000;
   localparam logic [PIXEL_BITS-1:0]  DATA_MAX_RST = 16'hFFFF;
   localparam logic [SCALE_BITS-1:0]  SCALE_RST    = 32'h0001_0000;
   localparam logic [OFFSET_BITS-1:0] OFFSET_RST   = '0;

   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic valid;
      logic map;
      logic last;
   } pcm_beat_type;

endpackage

>>> hw/rtl/pixel_colormap_mapper.sv
// Top level of the pixel colormap mapper: configuration, credit control and pipeline.
//
// Maps 16-bit pixels to palette colors and loads the palette from the same stream.
// One beat per cycle is taken while req_ready is high; a pixel's color reaches the
// response channel through range test and log2, multiply, offset add and clamp,
// palette read and result queue. Palette writes and pixel lookups share the
// single palette port in stream order, so a write affects exactly the pixels
// that follow it. Up to eight pixels may be in flight; when the result queue
// and pipeline hold that many, req_ready drops until responses are taken.
// Palette entries that were never written read back undefined.
module pixel_colormap_mapper
   import pcm_pkg::*;
#(
   parameter int PALETTE_INDEX_BITS = PALETTE_INDEX_BITS_DEF,
   parameter int COLOR_BITS         = COLOR_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PIXEL_BITS-1:0]     req_entry_index,
   input  logic [COLOR_BITS-1:0]     req_entry_color,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   input  logic                      req_last_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [COLOR_BITS-1:0]     rsp_color,
   output logic                      rsp_last_out,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic                     log_mode_ff, log_shift_ff;
   logic [PIXEL_BITS-1:0]    data_min_ff, data_max_ff;
   logic [SCALE_BITS-1:0]    scale_ff;
   logic [OFFSET_BITS-1:0]   offset_ff;
   logic [FIFO_CNT_BITS-1:0] inflight_ff, inflight_in;

   pcm_beat_type                  in_beat, mem_beat, rd_beat;
   logic [PALETTE_INDEX_BITS-1:0] mem_addr;
   logic [COLOR_BITS-1:0]         mem_color, rd_color;
   logic                          acc_map, rsp_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_mode_ff  <= 1'b0;
         data_min_ff  <= DATA_MIN_RST;
         data_max_ff  <= DATA_MAX_RST;
         scale_ff     <= SCALE_RST;
         offset_ff    <= OFFSET_RST;
         log_shift_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LOG_MODE:  log_mode_ff  <= csr_wdata[0];
            REG_DATA_MIN:  data_min_ff  <= csr_wdata[PIXEL_BITS-1:0];
            REG_DATA_MAX:  data_max_ff  <= csr_wdata[PIXEL_BITS-1:0];
            REG_SCALE:     scale_ff     <= csr_wdata[SCALE_BITS-1:0];
            REG_OFFSET:    offset_ff    <= csr_wdata[OFFSET_BITS-1:0];
            REG_LOG_SHIFT: log_shift_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      req_ready      = inflight_ff < FIFO_CNT_BITS'(FIFO_DEPTH);
      in_beat.valid  = req_valid && req_ready;
      in_beat.map    = req_opcode;
      in_beat.last   = req_last_pixel;
      acc_map        = in_beat.valid && req_opcode;
      rsp_pop        = rsp_valid && rsp_ready;
      inflight_in    = inflight_ff + FIFO_CNT_BITS'(acc_map) - FIFO_CNT_BITS'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   pcm_index #(
      .PALETTE_INDEX_BITS (PALETTE_INDEX_BITS),
      .COLOR_BITS         (COLOR_BITS)
   ) u_index (
      .clock          (clock),
      .reset          (reset),
      .in_beat        (in_beat),
      .in_pixel       (req_pixel),
      .in_entry_index (req_entry_index),
      .in_entry_color (req_entry_color),
      .log_mode       (log_mode_ff),
      .data_min       (data_min_ff),
      .data_max       (data_max_ff),
      .scale          (scale_ff),
      .offset         (offset_ff),
      .log_shift      (log_shift_ff),
      .mem_beat       (mem_beat),
      .mem_addr       (mem_addr),
      .mem_color      (mem_color)
   );

   pcm_palette #(
      .PALETTE_INDEX_BITS (PALETTE_INDEX_BITS),
      .COLOR_BITS         (COLOR_BITS)
   ) u_palette (
      .clock     (clock),
      .reset     (reset),
      .mem_beat  (mem_beat),
      .mem_addr  (mem_addr),
      .mem_color (mem_color),
      .rd_beat   (rd_beat),
      .rd_color  (rd_color)
   );

   pcm_rsp_fifo #(
      .COLOR_BITS (COLOR_BITS)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_beat    (rd_beat),
      .push_color   (rd_color),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_color    (rsp_color),
      .rsp_last_out (rsp_last_out)
   );

endmodule

>>> hw/rtl/pcm_index.sv
// Palette address pipeline: range test, log2, scale multiply, offset add and clamp.
module pcm_index
   import pcm_pkg::*;
#(
   parameter int PALETTE_INDEX_BITS = PALETTE_INDEX_BITS_DEF,
   parameter int COLOR_BITS         = COLOR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcm_beat_type                  in_beat,
   input  logic [PIXEL_BITS-1:0]         in_pixel,
   input  logic [PIXEL_BITS-1:0]         in_entry_index,
   input  logic [COLOR_BITS-1:0]         in_entry_color,
   input  logic                          log_mode,
   input  logic [PIXEL_BITS-1:0]         data_min,
   input  logic [PIXEL_BITS-1:0]         data_max,
   input  logic [SCALE_BITS-1:0]         scale,
   input  logic [OFFSET_BITS-1:0]        offset,
   input  logic                          log_shift,
   output pcm_beat_type                  mem_beat,
   output logic [PALETTE_INDEX_BITS-1:0] mem_addr,
   output logic [COLOR_BITS-1:0]         mem_color
);

   localparam logic [PALETTE_INDEX_BITS-1:0] PAL_TOP = '1;

   pcm_beat_type                  s1_beat_ff, s2_beat_ff, s3_beat_ff;
   logic                          s1_over_ff, s1_under_ff, s2_over_ff, s2_under_ff;
   logic [X_BITS-1:0]             s1_x_ff;
   logic [PROD_BITS-1:0]          s2_prod_ff;
   logic [PALETTE_INDEX_BITS-1:0] s1_addr_ff, s2_addr_ff, s3_addr_ff, s3_addr_in;
   logic [COLOR_BITS-1:0]         s1_color_ff, s2_color_ff, s3_color_ff;
   logic [X_BITS-1:0]             s1_x_in;
   logic                          s1_over_in, s1_under_in;

   logic [LOG_IN_BITS-1:0]             log_v;
   logic [EXP_BITS-1:0]                log_e;
   logic [LOG_IN_BITS+FRAC_BITS-1:0]   log_sh;
   logic signed [SUM_BITS-1:0]         sum;

   always_comb begin
      log_v = {1'b0, in_pixel} + LOG_IN_BITS'(log_shift);
      log_e = '0;
      for (int i = 0; i < LOG_IN_BITS; i++) begin
         if (log_v[i]) begin
            log_e = EXP_BITS'(i);
         end
      end
      log_sh = {log_v, {FRAC_BITS{1'b0}}} >> log_e;
      if (log_mode) begin
         s1_x_in = X_BITS'({log_e, log_sh[FRAC_BITS-1:0]});
      end else begin
         s1_x_in = in_pixel;
      end
      s1_over_in  = in_pixel >= data_max;
      s1_under_in = in_pixel <= data_min;
   end

   always_comb begin
      sum = $signed({2'b00, s2_prod_ff}) + $signed({offset[OFFSET_BITS-1], offset});
      if (!s2_beat_ff.map) begin
         s3_addr_in = s2_addr_ff;
      end else if (s2_over_ff) begin
         s3_addr_in = PAL_TOP;
      end else if (s2_under_ff || sum[SUM_BITS-1]) begin
         s3_addr_in = '0;
      end else if (|sum[SUM_BITS-2:FRAC_SHIFT+PALETTE_INDEX_BITS]) begin
         s3_addr_in = PAL_TOP;
      end else begin
         s3_addr_in = sum[FRAC_SHIFT+PALETTE_INDEX_BITS-1:FRAC_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_beat_ff <= '0;
         s2_beat_ff <= '0;
         s3_beat_ff <= '0;
      end else begin
         s1_beat_ff <= in_beat;
         s2_beat_ff <= s1_beat_ff;
         s3_beat_ff <= s2_beat_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_over_ff  <= s1_over_in;
      s1_under_ff <= s1_under_in;
      s1_x_ff     <= s1_x_in;
      s1_addr_ff  <= in_entry_index[PALETTE_INDEX_BITS-1:0];
      s1_color_ff <= in_entry_color;
      s2_over_ff  <= s1_over_ff;
      s2_under_ff <= s1_under_ff;
      s2_prod_ff  <= PROD_BITS'(scale) * PROD_BITS'(s1_x_ff);
      s2_addr_ff  <= s1_addr_ff;
      s2_color_ff <= s1_color_ff;
      s3_addr_ff  <= s3_addr_in;
      s3_color_ff <= s2_color_ff;
   end

   assign mem_beat  = s3_beat_ff;
   assign mem_addr  = s3_addr_ff;
   assign mem_color = s3_color_ff;

endmodule

>>> hw/rtl/pcm_palette.sv
// Palette memory: single port, writes and lookups in stream order, registered read.
module pcm_palette
   import pcm_pkg::*;
#(
   parameter int PALETTE_INDEX_BITS = PALETTE_INDEX_BITS_DEF,
   parameter int COLOR_BITS         = COLOR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pcm_beat_type                  mem_beat,
   input  logic [PALETTE_INDEX_BITS-1:0] mem_addr,
   input  logic [COLOR_BITS-1:0]         mem_color,
   output pcm_beat_type                  rd_beat,
   output logic [COLOR_BITS-1:0]         rd_color
);

   localparam int PAL_DEPTH = 2 ** PALETTE_INDEX_BITS;

   logic [COLOR_BITS-1:0] pal_mem [PAL_DEPTH];
   logic [COLOR_BITS-1:0] rd_color_ff;
   pcm_beat_type          rd_beat_ff;

   always_ff @(posedge clock) begin
      if (mem_beat.valid && !mem_beat.map) begin
         pal_mem[mem_addr] <= mem_color;
      end
      rd_color_ff <= pal_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_beat_ff <= '0;
      end else begin
         rd_beat_ff.valid <= mem_beat.valid && mem_beat.map;
         rd_beat_ff.map   <= mem_beat.map;
         rd_beat_ff.last  <= mem_beat.last;
      end
   end

   assign rd_beat  = rd_beat_ff;
   assign rd_color = rd_color_ff;

endmodule

>>> hw/rtl/pcm_rsp_fifo.sv
// Result queue between the palette read and the response channel.
module pcm_rsp_fifo
   import pcm_pkg::*;
#(
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pcm_beat_type          push_beat,
   input  logic [COLOR_BITS-1:0] push_color,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COLOR_BITS-1:0] rsp_color,
   output logic                  rsp_last_out
);

   logic [COLOR_BITS-1:0]    color_q [FIFO_DEPTH];
   logic                     last_q  [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     push, pop;

   always_comb begin
      push      = push_beat.valid && push_beat.map;
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      cnt_in    = cnt_ff + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         color_q[wr_ptr_ff] <= push_color;
         last_q[wr_ptr_ff]  <= push_beat.last;
      end
   end

   assign rsp_valid    = cnt_ff != '0;
   assign rsp_color    = color_q[rd_ptr_ff];
   assign rsp_last_out = last_q[rd_ptr_ff];

endmodule

>>> sim/pcm_checker.sv
`timescale 1ns / 1ps
// Checker for the pixel colormap mapper: palette and register shadow, color prediction, compare.
module pcm_checker
   import pcm_pkg::*;
#(
   parameter logic MAP_OPCODE = 1'b1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [PIXEL_BITS-1:0]     req_entry_index,
   input  logic [31:0]               req_entry_color,
   input  logic [PIXEL_BITS-1:0]     req_pixel,
   input  logic                      req_last_pixel,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [31:0]               rsp_color,
   input  logic                      rsp_last_out,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending_count
);

   localparam logic [15:0] ENTRY_TOP = 16'hFFFF;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [31:0] color;
      logic        last;
   } lookup_type;

   logic [31:0]             palette_words [0:65535];
   logic                    log_mode;
   logic [15:0]             data_min;
   logic [15:0]             data_max;
   logic [31:0]             scale;
   logic signed [48:0]      offset;
   logic                    log_shift;
   lookup_type              expected_colors [$];

   function automatic logic [15:0] log2_q6_10(input logic [16:0] v);
      int          msb;
      logic [16:0] rest;
      logic [26:0] mant;
      msb = 0;
      for (int b = 0; b < 17; b++)
         if (v[b]) msb = b;
      if (v == 17'd0) return 16'd0;
      rest = v - (17'd1 << msb);
      mant = {rest, 10'd0} >> msb;
      return {msb[5:0], mant[9:0]};
   endfunction

   function automatic logic [15:0] palette_entry_for(input logic [15:0] pix);
      logic [15:0]        x;
      logic signed [63:0] sum;
      logic [63:0]        idx;
      if (pix >= data_max) return ENTRY_TOP;
      if (pix <= data_min) return 16'd0;
      if (log_mode) x = log2_q6_10({1'b0, pix} + {16'd0, log_shift});
      else x = pix;
      sum = $signed(64'(scale) * 64'(x)) + $signed({{15{offset[48]}}, offset});
      if (sum < 0) return 16'd0;
      idx = 64'(sum) >> 16;
      if (idx > 64'(ENTRY_TOP)) return ENTRY_TOP;
      return idx[15:0];
   endfunction

   always @(posedge clock) begin
      lookup_type seen;
      lookup_type want;
      if (reset) begin
         log_mode <= 1'b0;
         data_min <= DATA_MIN_RST;
         data_max <= DATA_MAX_RST;
         scale <= SCALE_RST;
         offset <= OFFSET_RST;
         log_shift <= 1'b0;
         expected_colors.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_LOG_MODE: begin
                  log_mode <= csr_wdata[0];
               end
               REG_DATA_MIN: begin
                  data_min <= csr_wdata[15:0];
               end
               REG_DATA_MAX: begin
                  data_max <= csr_wdata[15:0];
               end
               REG_SCALE: begin
                  scale <= csr_wdata[31:0];
               end
               REG_OFFSET: begin
                  offset <= csr_wdata;
               end
               REG_LOG_SHIFT: begin
                  log_shift <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{color: rsp_color, last: rsp_last_out};
            if (expected_colors.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("unexpected result beat: color %h last %0b", seen.color, seen.last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_colors.pop_front();
               if (seen.color !== want.color || seen.last !== want.last) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("mismatch: expected color %h last %0b, got color %h last %0b",
                        want.color, want.last, seen.color, seen.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == MAP_OPCODE) begin
               want.color = palette_words[palette_entry_for(req_pixel)];
               want.last = req_last_pixel;
               expected_colors.push_back(want);
            end else begin
               palette_words[req_entry_index] <= req_entry_color;
            end
         end
      end
      pending_count <= expected_colors.size();
   end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the pixel colormap mapper testbench: clock, reset, stimulus and verdict.
module testbench;
   import pcm_pkg::*;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MAP   = 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;
   localparam logic [15:0] PIXEL_TOP = 16'hFFFF;
   localparam logic [48:0] OFFSET_MOST = 49'h0_FFFF_FFFF_FFFF;
   localparam logic [48:0] OFFSET_LEAST = 49'h1_0000_0000_0000;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 10;
   localparam int TAIL_CYCLES   = 20;
   localparam int NUM_PHASES    = 16;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_opcode = OP_WRITE;
   logic [PIXEL_BITS-1:0]     req_entry_index = '0;
   logic [31:0]               req_entry_color = '0;
   logic [PIXEL_BITS-1:0]     req_pixel = '0;
   logic                      req_last_pixel = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [31:0]               rsp_color;
   logic                      rsp_last_out;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int   fail_count;
   int   pending;
   int   idle_cycles = 0;
   int   rsp_wait = 0;
   logic rsp_taken = 1'b0;
   logic rsp_rush = 1'b0;
   logic req_rush = 1'b0;
   logic [15:0] cfg_min = DATA_MIN_RST;
   logic [15:0] cfg_max = DATA_MAX_RST;

   always #10 clock = ~clock;

   pixel_colormap_mapper u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_entry_color(req_entry_color),
      .req_pixel(req_pixel),
      .req_last_pixel(req_last_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_color(rsp_color),
      .rsp_last_out(rsp_last_out),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pcm_checker #(.MAP_OPCODE(OP_MAP)) u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_entry_color(req_entry_color),
      .req_pixel(req_pixel),
      .req_last_pixel(req_last_pixel),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_color(rsp_color),
      .rsp_last_out(rsp_last_out),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .pending_count(pending)
   );

   always @(posedge clock) begin
      rsp_taken <= rsp_valid && rsp_ready;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rsp_taken) rsp_wait = rsp_rush ? 0 : $urandom_range(0, 16);
      if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(input logic op, input logic [15:0] idx, input logic [31:0] col,
                            input logic [15:0] pix, input logic last);
      int gap;
      gap = req_rush ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode <= op;
      req_entry_index <= idx;
      req_entry_color <= col;
      req_pixel <= pix;
      req_last_pixel <= last;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_entry(input logic [15:0] idx, input logic [31:0] col);
      send_beat(OP_WRITE, idx, col, 16'($urandom), 1'($urandom));
   endtask

   task automatic map_pixel(input logic [15:0] pix, input logic last);
      send_beat(OP_MAP, 16'($urandom), 32'($urandom), pix, last);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                          input logic [CSR_DATA_BITS-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_write_enable <= 1'b1;
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic mode, input logic [15:0] dmin,
                                input logic [15:0] dmax, input logic [31:0] scl,
                                input logic [48:0] ofs, input logic shift, input logic spare);
      put_reg(REG_LOG_MODE, 49'(mode));
      put_reg(REG_DATA_MIN, 49'(dmin));
      put_reg(REG_DATA_MAX, 49'(dmax));
      put_reg(REG_SCALE, 49'(scl));
      put_reg(REG_OFFSET, ofs);
      put_reg(REG_LOG_SHIFT, 49'(shift));
      if (spare) begin
         put_reg(REG_SPARE_A, {17'($urandom), 32'($urandom)});
         put_reg(REG_SPARE_B, {17'($urandom), 32'($urandom)});
      end
      csr_write_enable <= 1'b0;
      cfg_min = dmin;
      cfg_max = dmax;
   endtask

   function automatic logic [15:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return cfg_min;
         1: return cfg_min + 16'd1;
         2: return cfg_max;
         3: return cfg_max - 16'd1;
         4: return 16'd0;
         5: return PIXEL_TOP;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [48:0] pick_offset();
      if ($urandom_range(0, 3) == 0) return {1'($urandom), 32'($urandom), 16'($urandom)};
      return 49'($urandom_range(0, 32'h7FFF_FFFF)) - 49'h3FFF_FFFF;
   endfunction

   task automatic run_items(input int count);
      req_rush = ($urandom_range(0, 3) == 0);
      rsp_rush = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) load_entry(16'($urandom), 32'($urandom));
         else map_pixel(pick_pixel(), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      logic        mode;
      logic [15:0] dmin;
      logic [15:0] dmax;
      logic [31:0] scl;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // fill the whole palette back to back so no lookup hits an unwritten entry
      req_rush = 1'b1;
      for (int i = 0; i <= 65535; i++) load_entry(16'(i), 32'($urandom));
      req_rush = 1'b0;

      load_entry(16'd0, 32'd0);
      load_entry(PIXEL_TOP, 32'hFFFF_FFFF);
      map_pixel(16'd0, 1'b0);
      map_pixel(PIXEL_TOP, 1'b1);
      map_pixel(16'd1, 1'b0);
      map_pixel(16'h8000, 1'b1);
      map_pixel(PIXEL_TOP - 16'd1, 1'b0);
      load_entry(16'd0, 32'hFFFF_FFFF);
      map_pixel(16'd0, 1'b1);
      load_entry(PIXEL_TOP, 32'd0);
      map_pixel(PIXEL_TOP, 1'b0);
      map_pixel(16'h7FFF, 1'b1);

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         drain();
         case (phase)
            1: apply_setting(1'b0, 16'd0, PIXEL_TOP, 32'hFFFF_FFFF, OFFSET_MOST, 1'b0, 1'b0);
            2: apply_setting(1'b0, 16'd0, PIXEL_TOP, 32'd0, OFFSET_LEAST, 1'b1, 1'b1);
            3: apply_setting(1'b0, 16'd40000, 16'd20000, SCALE_RST, 49'd0, 1'b0, 1'b0);
            4: apply_setting(1'b1, 16'd0, 16'd0, SCALE_RST, 49'd0, 1'b1, 1'b0);
            5: apply_setting(1'b1, 16'd0, PIXEL_TOP, 32'h0004_0000, 49'd0, 1'b1, 1'b0);
            6: apply_setting(1'b1, 16'd0, PIXEL_TOP, 32'h0003_0000, pick_offset(), 1'b0, 1'b1);
            7: apply_setting(1'b0, PIXEL_TOP, PIXEL_TOP, 32'($urandom), pick_offset(), 1'b0,
                  1'b0);
            8: apply_setting(1'b1, 16'($urandom_range(0, 500)), 16'($urandom_range(600, 65535)),
                  32'hFFFF_FFFF, OFFSET_LEAST, 1'b1, 1'b0);
            default: begin
               mode = 1'($urandom);
               dmin = 16'($urandom_range(0, 20000));
               dmax = 16'($urandom_range(int'(dmin) + 1, 65535));
               if ($urandom_range(0, 3) == 0) scl = $urandom;
               else if (mode) scl = $urandom_range(32'h1_0000, 32'h5_0000);
               else scl = $urandom_range(32'h8000, 32'h3_0000);
               apply_setting(mode, dmin, dmax, scl, pick_offset(), 1'($urandom),
                  $urandom_range(0, 3) == 0);
            end
         endcase
         run_items(phase <= 8 ? 40 : 125);
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> pixel_colormap_mapper.f
hw/rtl/pcm_pkg.sv
hw/rtl/pcm_index.sv
hw/rtl/pcm_palette.sv
hw/rtl/pcm_rsp_fifo.sv
hw/rtl/pixel_colormap_mapper.sv
sim/pcm_checker.sv
sim/testbench.sv
